[rtl/assert_macros.svh]
// Assertion macros used by the RTL of the key-value table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[rtl/tkv_pkg.sv]
// Package: widths, codes and cell-to-cell structs of the key-value table.
`default_nettype none
package tkv_pkg;
    localparam int ENTRIES_DEF = 64;
    localparam int KEY_BYTES   = 8;
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 32;
    localparam int CMD_W       = 3;
    localparam int ST_W        = 2;

    localparam logic [CMD_W-1:0] CMD_SET_INT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_FLOAT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET_INT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET_FLOAT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd4;

    localparam logic [ST_W-1:0] STAT_OK        = 2'd0;
    localparam logic [ST_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [ST_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] STAT_MISMATCH  = 2'd3;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic             valid;
        logic             match_seen;
        logic             free_seen;
        logic             match_float;
        logic [VAL_W-1:0] match_value;
    } token_t;

    // Write-back broadcast to all cells.
    typedef struct packed {
        logic             en;
        logic             use_match;
        logic [KEY_W-1:0] key;
        logic             as_float;
        logic [VAL_W-1:0] value;
    } wr_t;
endpackage
`default_nettype wire

[rtl/tkv_req_if.sv]
// Request channel interface: command, key and value to write.
`default_nettype none
interface tkv_req_if;
    logic                      valid;
    logic                      ready;
    logic [tkv_pkg::CMD_W-1:0] cmd;
    logic [tkv_pkg::KEY_W-1:0] key;
    logic [tkv_pkg::VAL_W-1:0] write_value;

    modport source (output valid, output cmd, output key, output write_value, input ready);
    modport sink (input valid, input cmd, input key, input write_value, output ready);
endinterface
`default_nettype wire

[rtl/tkv_rsp_if.sv]
// Response channel interface: success flag, status code and read value.
`default_nettype none
interface tkv_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic [tkv_pkg::ST_W-1:0]  status;
    logic [tkv_pkg::VAL_W-1:0] read_value;

    modport source (output valid, output ok, output status, output read_value, input ready);
    modport sink (input valid, input ok, input status, input read_value, output ready);
endinterface
`default_nettype wire

[rtl/tkv_cell.sv]
// One slot of the table: stored key, type and value, plus one search stage.
`default_nettype none
module tkv_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [tkv_pkg::KEY_W-1:0] key,
    input  wire tkv_pkg::token_t           tok_in,
    output tkv_pkg::token_t                tok_out,
    input  wire tkv_pkg::wr_t              wr
);
    logic [tkv_pkg::KEY_W-1:0] key_reg;
    logic                      float_reg;
    logic [tkv_pkg::VAL_W-1:0] value_reg;
    logic                      hit_reg;
    logic                      hit_next;
    logic                      free_reg;
    logic                      free_next;
    tkv_pkg::token_t           tok_reg;
    tkv_pkg::token_t           tok_next;
    logic                      slot_free;
    logic                      match;
    logic                      sel;

    assign slot_free = (key_reg[7:0] == 8'd0);
    assign match     = !slot_free && (key_reg == key);
    assign sel       = wr.use_match ? hit_reg : free_reg;

    always_comb
    begin
        tok_next  = tok_in;
        hit_next  = hit_reg;
        free_next = free_reg;
        if (tok_in.valid)
        begin
            // Claim first match and first free slot as the token passes.
            hit_next  = match && !tok_in.match_seen;
            free_next = slot_free && !tok_in.free_seen;
            if (hit_next)
            begin
                tok_next.match_float = float_reg;
                tok_next.match_value = value_reg;
            end
            tok_next.match_seen = tok_in.match_seen | match;
            tok_next.free_seen  = tok_in.free_seen | slot_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            float_reg <= 1'b0;
            value_reg <= '0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            hit_reg  <= hit_next;
            free_reg <= free_next;
            tok_reg  <= tok_next;
            if (wr.en && sel)
            begin
                key_reg   <= wr.key;
                float_reg <= wr.as_float;
                value_reg <= wr.value;
            end
        end
    end

    assign tok_out = tok_reg;
endmodule
`default_nettype wire

[rtl/typed_key_value_table_top.sv]
// Top level: typed key-value table built as a chain of slot cells.
// A new request is taken only while the table is idle, not before the last one
// has finished; the search token walks the cell chain one slot per cycle, then
// the write-back follows once the response register is free.
// A finished response waits in its output register while the next scan runs.
// Reset (rst_n low, asynchronous) clears all slots to free and all control.
`default_nettype none
`include "assert_macros.svh"
module typed_key_value_table_top #(
    parameter int ENTRIES = tkv_pkg::ENTRIES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tkv_req_if.sink   req,
    tkv_rsp_if.source rsp
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic [tkv_pkg::CMD_W-1:0] cmd_reg;
    logic [tkv_pkg::KEY_W-1:0] key_reg;
    logic [tkv_pkg::VAL_W-1:0] wval_reg;
    logic                      start_reg;
    tkv_pkg::token_t           last_reg;
    logic                      out_valid_reg;
    logic                      ok_reg;
    logic [tkv_pkg::ST_W-1:0]  status_reg;
    logic [tkv_pkg::VAL_W-1:0] rval_reg;

    logic [tkv_pkg::KEY_W-1:0] norm_key;
    logic                      accept;
    logic                      fin_go;
    logic                      res_ok;
    logic [tkv_pkg::ST_W-1:0]  res_status;
    logic [tkv_pkg::VAL_W-1:0] res_value;
    tkv_pkg::wr_t              wr;
    tkv_pkg::token_t           tok [ENTRIES+1];

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign fin_go = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    // Normalize the key: keep bytes up to the first zero, within KEY_BYTES.
    always_comb
    begin
        logic stop;
        norm_key = '0;
        stop     = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (i >= tkv_pkg::KEY_BYTES || req.key[8*i +: 8] == 8'd0)
                stop = 1'b1;
            if (!stop)
                norm_key[8*i +: 8] = req.key[8*i +: 8];
        end
    end

    // Inject a fresh token in the cycle after the request is accepted.
    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = start_reg;
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            tkv_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .key    (key_reg),
                .tok_in (tok[g]),
                .tok_out(tok[g+1]),
                .wr     (wr)
            );
        end
    endgenerate

    // Decide the result and the write-back from the finished token.
    always_comb
    begin
        res_ok       = 1'b0;
        res_status   = tkv_pkg::STAT_NOT_FOUND;
        res_value    = '0;
        wr           = '0;
        wr.key      = key_reg;
        wr.value    = wval_reg;
        wr.use_match = last_reg.match_seen;
        case (cmd_reg)
            tkv_pkg::CMD_SET_INT,
            tkv_pkg::CMD_SET_FLOAT:
            begin
                wr.as_float = (cmd_reg == tkv_pkg::CMD_SET_FLOAT);
                if (last_reg.match_seen || last_reg.free_seen)
                begin
                    wr.en      = fin_go;
                    res_ok     = 1'b1;
                    res_status = tkv_pkg::STAT_OK;
                end
                else
                begin
                    res_status = tkv_pkg::STAT_FULL;
                end
            end
            tkv_pkg::CMD_GET_INT,
            tkv_pkg::CMD_GET_FLOAT:
            begin
                if (!last_reg.match_seen)
                    res_status = tkv_pkg::STAT_NOT_FOUND;
                else if (last_reg.match_float != (cmd_reg == tkv_pkg::CMD_GET_FLOAT))
                    res_status = tkv_pkg::STAT_MISMATCH;
                else
                begin
                    res_ok     = 1'b1;
                    res_status = tkv_pkg::STAT_OK;
                    res_value  = last_reg.match_value;
                end
            end
            tkv_pkg::CMD_REMOVE:
            begin
                // Clear the matching slot back to free.
                wr.key   = '0;
                wr.value = '0;
                if (last_reg.match_seen)
                begin
                    wr.en      = fin_go;
                    res_ok     = 1'b1;
                    res_status = tkv_pkg::STAT_OK;
                end
            end
            default:
            begin
                res_status = tkv_pkg::STAT_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_SCAN;
            S_SCAN:  if (tok[ENTRIES].valid) state_next = S_FIN;
            S_FIN:   if (fin_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (fin_go)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: request latch, finished token, response.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.cmd;
            key_reg  <= norm_key;
            wval_reg <= req.write_value;
        end
        if (tok[ENTRIES].valid)
            last_reg <= tok[ENTRIES];
        if (fin_go)
        begin
            ok_reg     <= res_ok;
            status_reg <= res_status;
            rval_reg   <= res_value;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = ok_reg;
    assign rsp.status     = status_reg;
    assign rsp.read_value = rval_reg;

    // Each injected token comes out at the end of the chain.
    `ASSERT_CLK(a_scan_len, clk, rst_n, start_reg |-> ##ENTRIES tok[ENTRIES].valid)
    // A finished token never shows up outside a scan.
    `ASSERT_NEVER(a_tok_stray, clk, rst_n, tok[ENTRIES].valid && (state_reg != S_SCAN))
    // A write-back always comes with a response loaded.
    `ASSERT_CLK(a_wr_resp, clk, rst_n, wr.en |=> out_valid_reg)
endmodule
`default_nettype wire
